[rtl/sparse_triplet_fast_transpose_unit_assert.svh]
// ----------------------------------------------------------------------------
// sparse triplet fast transpose - assertion macros
// Wrappers that clock the properties on the block clock and report by $error.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_FAST_TRANSPOSE_UNIT_ASSERT_SVH
`define SPARSE_TRIPLET_FAST_TRANSPOSE_UNIT_ASSERT_SVH

// checked only out of reset
`define STFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define STFT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/stft_pkg.sv]
// ----------------------------------------------------------------------------
// stft_pkg
// Shared types, constants and controller states of the sparse fast transpose.
// ----------------------------------------------------------------------------
`default_nettype none

package stft_pkg;

   localparam int MAX_TERMS_DEFAULT = 64;
   localparam int MAX_DIM_DEFAULT   = 16;

   localparam int IDX_FIELD_W  = 4;
   localparam int VALUE_W      = 32;
   localparam int SLOT_FIELD_W = 7;
   localparam int NUM_COLS_W   = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes, taken from paddr[2]
   localparam logic CSR_NUM_COLS = 1'b0;

   localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 5'd16;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0]   in_row;
      logic [IDX_FIELD_W-1:0]   in_col;
      logic signed [VALUE_W-1:0] in_value;
      logic                     in_last;
   } req_type;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0]    out_row;
      logic [IDX_FIELD_W-1:0]    out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic [SLOT_FIELD_W-1:0]   out_slot;
      logic                      out_last;
      logic                      out_overflow;
   } rsp_type;

   // one stored triplet
   typedef struct packed {
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
      logic [VALUE_W-1:0]     value;
   } term_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREFIX,
      ST_SCAT_RD,
      ST_SCATTER,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // request accepted this cycle
      logic clear;       // drop load state for the next matrix
      logic pre_init;
      logic pre_step;
      logic scan_init;   // index to zero, read entry zero
      logic scan_step;   // index up by one, read next entry
      logic scatter_wr;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic pre_done;
      logic idx_last;
   } ctl_status_type;

endpackage

`default_nettype wire

[rtl/sparse_triplet_fast_transpose_unit.sv]
// ----------------------------------------------------------------------------
// sparse_triplet_fast_transpose_unit
// Transposes a sparse matrix given as row-major (row, column, value) triplets.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one triplet per request, row-major, in_last on the final one.
//    Requests are taken one per cycle while the block is loading.
//  - rsp channel: after the marked request the block emits the transposed list
//    in slot order, slot counting from 1, out_last on the final term.
//  - After the marked request the block runs a prefix sum over the column
//    counters, then a scatter of the stored terms (one term a cycle through
//    the store's registered read port), then a read state, then one result
//    per cycle while rsp_ready is high.
//  - No requests are taken from the marked request until the last result is
//    accepted. A stalled receiver holds the current result in place.
//  - Terms past MAX_TERMS are dropped and flag out_overflow; terms whose column
//    is not below num_cols (taken as one when zero) or MAX_DIM are dropped silently.
//  - csr port: num_cols at address 0; write only while the block is idle.
//  - Synchronous reset clears the counters and returns to loading, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_triplet_fast_transpose_unit_assert.svh"

module sparse_triplet_fast_transpose_unit
   import stft_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEFAULT,
   parameter int MAX_DIM   = MAX_DIM_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [NUM_COLS_W-1:0] num_cols_ff;
   logic                  csr_wr;
   logic                  req_fire;
   logic                  rsp_fire;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= NUM_COLS_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_NUM_COLS)) begin
         num_cols_ff <= csr_pwdata[NUM_COLS_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_NUM_COLS) begin
         csr_prdata = CSR_DATA_W'(num_cols_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   stft_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.in_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stft_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .MAX_DIM   (MAX_DIM)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .num_cols (num_cols_ff),
      .rsp_data (rsp_data)
   );

   // loading and emitting never overlap
   `STFT_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "load and emit overlap")
   // emission runs without gaps until the last term
   `STFT_ASSERT(a_emit_cont, (rsp_fire && !rsp_data.out_last) |=> rsp_valid, "gap in emission")
   // last term returns the block to loading
   `STFT_ASSERT(a_back_to_load, (rsp_fire && rsp_data.out_last) |=> req_ready, "no return to load")
   // a marked request closes the load phase
   `STFT_ASSERT(a_mark_stops, (req_fire && req_data.in_last) |=> !req_ready, "load not closed")

endmodule

`default_nettype wire

[rtl/stft_controller.sv]
// ----------------------------------------------------------------------------
// stft_controller
// Sequencer for load, prefix sum, scatter and emission phases.
// ----------------------------------------------------------------------------
`default_nettype none

module stft_controller
   import stft_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (status.pre_done) begin
               // empty matrix emits nothing
               state_in = status.count_zero ? ST_LOAD : ST_SCAT_RD;
            end
         end
         ST_SCAT_RD: begin
            state_in = ST_SCATTER;
         end
         ST_SCATTER: begin
            if (status.idx_last) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && status.idx_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready    = 1'b1;
            cmd.load     = req_valid;
            cmd.pre_init = req_valid && req_last;
         end
         ST_PREFIX: begin
            cmd.pre_step = 1'b1;
            cmd.clear    = status.pre_done && status.count_zero;
         end
         ST_SCAT_RD: begin
            cmd.scan_init = 1'b1;
         end
         ST_SCATTER: begin
            cmd.scatter_wr = 1'b1;
            cmd.scan_step  = 1'b1;
         end
         ST_EMIT_RD: begin
            cmd.scan_init = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.scan_step = rsp_ready;
            cmd.clear     = rsp_ready && status.idx_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/stft_datapath.sv]
// ----------------------------------------------------------------------------
// stft_datapath
// Term stores, column counters, column start table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stft_datapath
   import stft_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEFAULT,
   parameter int MAX_DIM   = MAX_DIM_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_cmd_type           cmd,
   output ctl_status_type             status,
   input  wire req_type               req_data,
   input  wire logic [NUM_COLS_W-1:0] num_cols,
   output rsp_type                    rsp_data
);

   localparam int IDX_W  = $clog2(MAX_TERMS);
   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int SLOT_W = $clog2(MAX_TERMS + 2);
   localparam int DIM_W  = $clog2(MAX_DIM);

   term_type term_mem [MAX_TERMS];
   term_type trans_mem [MAX_TERMS];

   term_type          term_rd_ff;
   term_type          trans_rd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              ovf_ff;
   logic [CNT_W-1:0]  col_cnt_ff [MAX_DIM];
   logic [SLOT_W-1:0] col_start_ff [MAX_DIM];
   logic [SLOT_W-1:0] run_ff;
   logic [DIM_W-1:0]  sweep_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic             col_ok;
   logic             full;
   logic [DIM_W-1:0] col_idx;
   logic [DIM_W-1:0] sc_col;
   logic [SLOT_W-1:0] sc_slot;
   logic [IDX_W-1:0] rd_addr;
   term_type         trans_wr;

   // zero columns act as one, more than the table holds act as the table size
   assign col_ok = ((32'(req_data.in_col) < 32'(num_cols)) ||
                    ((num_cols == '0) && (req_data.in_col == '0))) &&
                   (32'(req_data.in_col) < 32'(MAX_DIM));
   assign full    = (count_ff == CNT_W'(MAX_TERMS));
   assign col_idx = DIM_W'(req_data.in_col);

   assign sc_col  = DIM_W'(term_rd_ff.col);
   assign sc_slot = col_start_ff[sc_col];

   assign trans_wr.row   = term_rd_ff.col;
   assign trans_wr.col   = term_rd_ff.row;
   assign trans_wr.value = term_rd_ff.value;

   always_comb begin
      if (cmd.scan_init) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   // load state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < MAX_DIM; i++) begin
            col_cnt_ff[i] <= '0;
         end
      end else if (cmd.load && col_ok) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff            <= count_ff + CNT_W'(1);
            col_cnt_ff[col_idx] <= col_cnt_ff[col_idx] + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && col_ok && !full) begin
         term_mem[IDX_W'(count_ff)] <= '{row:   req_data.in_row,
                                          col:   req_data.in_col,
                                          value: req_data.in_value};
      end
      term_rd_ff <= term_mem[rd_addr];
   end

   // prefix sum, one column a cycle, then bumped per scattered term
   always_ff @(posedge clock) begin
      if (cmd.pre_init) begin
         run_ff   <= SLOT_W'(1);
         sweep_ff <= '0;
      end else if (cmd.pre_step) begin
         run_ff   <= run_ff + SLOT_W'(col_cnt_ff[sweep_ff]);
         sweep_ff <= sweep_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pre_step) begin
         col_start_ff[sweep_ff] <= run_ff;
      end else if (cmd.scatter_wr) begin
         col_start_ff[sc_col] <= sc_slot + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scatter_wr) begin
         trans_mem[IDX_W'(sc_slot - SLOT_W'(1))] <= trans_wr;
      end
      trans_rd_ff <= trans_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init || cmd.scan_step) begin
         idx_ff <= rd_addr;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.pre_done   = (sweep_ff == DIM_W'(MAX_DIM - 1));
   assign status.idx_last   = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));

   assign rsp_data.out_row      = trans_rd_ff.row;
   assign rsp_data.out_col      = trans_rd_ff.col;
   assign rsp_data.out_value    = trans_rd_ff.value;
   assign rsp_data.out_slot     = SLOT_FIELD_W'(CNT_W'(idx_ff) + CNT_W'(1));
   assign rsp_data.out_last     = status.idx_last;
   assign rsp_data.out_overflow = ovf_ff;

endmodule

`default_nettype wire

[tb/tb_sparse_triplet_fast_transpose_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_triplet_fast_transpose_unit
// Self-checking bench for the sparse fast transpose. Matrices go in as
// triplet requests, a behavioral transpose predicts each emitted term and a
// checker compares every accepted result field by field, under several
// num_cols settings and idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_fast_transpose_unit;
   import stft_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam logic [CSR_ADDR_W-1:0] NUM_COLS_ADDR = {CSR_NUM_COLS, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // transpose predictor state
   rsp_type               expected_terms[$];
   term_type              held_terms[$];
   int unsigned           col_tally[MAX_DIM_DEFAULT];
   bit                    dropped_flag = 1'b0;
   logic [NUM_COLS_W-1:0] cfg_num_cols = NUM_COLS_RESET;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int rsp_hold_cycles = 0;
   int fail_count = 0;
   int requests_sent = 0;
   int matrices_sent = 0;
   int terms_checked = 0;

   sparse_triplet_fast_transpose_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("timeout at %0t, %0d terms still expected", $time, expected_terms.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned usable_cols();
      if (cfg_num_cols == 0) return 1;
      if (cfg_num_cols > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return 32'(cfg_num_cols);
   endfunction

   // loads one request; on the marked one, counts, scatters and emits
   function automatic void absorb_term(input req_type t);
      int unsigned next_slot[MAX_DIM_DEFAULT+1];
      term_type    placed[MAX_TERMS_DEFAULT];
      term_type    held;
      int unsigned n;
      int unsigned slot;
      rsp_type     r;
      if (t.in_col < usable_cols()) begin
         if (held_terms.size() < MAX_TERMS_DEFAULT) begin
            held.row = t.in_row;
            held.col = t.in_col;
            held.value = t.in_value;
            held_terms.push_back(held);
            col_tally[t.in_col]++;
         end else begin
            dropped_flag = 1'b1;
         end
      end
      if (!t.in_last) return;
      n = held_terms.size();
      next_slot[0] = 1;
      for (int i = 1; i <= MAX_DIM_DEFAULT; i++)
         next_slot[i] = next_slot[i-1] + col_tally[i-1];
      foreach (held_terms[i]) begin
         slot = next_slot[held_terms[i].col];
         next_slot[held_terms[i].col] = slot + 1;
         placed[slot-1].row = held_terms[i].col;
         placed[slot-1].col = held_terms[i].row;
         placed[slot-1].value = held_terms[i].value;
      end
      for (int i = 0; i < n; i++) begin
         r.out_row = placed[i].row;
         r.out_col = placed[i].col;
         r.out_value = placed[i].value;
         r.out_slot = SLOT_FIELD_W'(i + 1);
         r.out_last = (i + 1 == n);
         r.out_overflow = dropped_flag;
         expected_terms.push_back(r);
      end
      held_terms.delete();
      dropped_flag = 1'b0;
      foreach (col_tally[i]) col_tally[i] = 0;
      matrices_sent++;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_terms.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_terms.pop_front();
            check_field("out_row", 32'(want.out_row), 32'(rsp_data.out_row));
            check_field("out_col", 32'(want.out_col), 32'(rsp_data.out_col));
            check_field("out_value", 32'(want.out_value), 32'(rsp_data.out_value));
            check_field("out_slot", 32'(want.out_slot), 32'(rsp_data.out_slot));
            check_field("out_last", 32'(want.out_last), 32'(rsp_data.out_last));
            check_field("out_overflow", 32'(want.out_overflow),
                        32'(rsp_data.out_overflow));
            terms_checked++;
         end
      end
   end

   // receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_term(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      absorb_term(t);
      @(negedge clock);
   endtask

   task automatic send_triplet(input logic [3:0] row, input logic [3:0] col,
                               input logic [31:0] value, input logic last);
      req_type t;
      t.in_row = row;
      t.in_col = col;
      t.in_value = value;
      t.in_last = last;
      send_term(t);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_terms.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_num_cols(input logic [NUM_COLS_W-1:0] cols);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= NUM_COLS_ADDR;
      csr_pwdata <= CSR_DATA_W'(cols);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cfg_num_cols = cols;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0};
         default: return $urandom;
      endcase
   endfunction

   // tidy matrices walk the rows in order with columns in range; others are noise
   task automatic send_random_matrix(input int unsigned len, input bit tidy);
      logic [3:0] row;
      logic [3:0] col;
      int unsigned step;
      row = 4'($urandom_range(3));
      for (int k = 0; k < len; k++) begin
         if (tidy) begin
            if ($urandom_range(2) == 0) begin
               step = $urandom_range(1, 3);
               row = (row + step > 15) ? 4'd15 : 4'(row + step);
            end
            col = 4'($urandom_range(usable_cols() - 1));
         end else begin
            row = 4'($urandom);
            col = 4'($urandom);
         end
         send_triplet(row, col, random_value(), k == len - 1);
      end
   endtask

   task automatic test_extremes();
      write_num_cols(5'd16);
      send_triplet(4'd15, 4'd15, 32'h7fff_ffff, 1'b1);
      send_triplet(4'd0, 4'd0, 32'h8000_0000, 1'b1);
      send_triplet(4'd0, 4'd15, 32'hffff_ffff, 1'b0);
      send_triplet(4'd3, 4'd0, 32'h0000_0000, 1'b0);
      send_triplet(4'd3, 4'd15, 32'h5a5a_5a5a, 1'b0);
      send_triplet(4'd15, 4'd7, 32'ha5a5_a5a5, 1'b1);
   endtask

   task automatic test_column_range();
      // zero columns acts as one: only column 0 survives, dropped mark still ends
      write_num_cols(5'd0);
      send_triplet(4'd2, 4'd0, 32'd11, 1'b0);
      send_triplet(4'd2, 4'd1, 32'd22, 1'b0);
      send_triplet(4'd9, 4'd15, 32'd33, 1'b0);
      send_triplet(4'd9, 4'd0, 32'd44, 1'b0);
      send_triplet(4'd12, 4'd3, 32'd55, 1'b1);
      // empty matrix
      send_triplet(4'd4, 4'd1, 32'd66, 1'b1);
      write_num_cols(5'd31);
      send_triplet(4'd1, 4'd15, -32'sd7, 1'b1);
      write_num_cols(5'd5);
      send_triplet(4'd6, 4'd4, 32'd1, 1'b0);
      send_triplet(4'd6, 4'd5, 32'd2, 1'b1);
   endtask

   task automatic test_midload_reconfig();
      write_num_cols(5'd16);
      send_triplet(4'd1, 4'd9, 32'd100, 1'b0);
      send_triplet(4'd1, 4'd2, 32'd200, 1'b0);
      write_num_cols(5'd4);
      send_triplet(4'd2, 4'd9, 32'd300, 1'b0);
      send_triplet(4'd2, 4'd3, 32'd400, 1'b1);
   endtask

   task automatic test_store_overflow();
      write_num_cols(5'd16);
      send_idle_pct = 0;
      stall_pct = 0;
      send_random_matrix(MAX_TERMS_DEFAULT + 2, 1'b1);
      send_random_matrix(MAX_TERMS_DEFAULT, 1'b1);
   endtask

   task automatic test_receiver_holdoff();
      write_num_cols(5'd16);
      send_idle_pct = 0;
      stall_pct = 0;
      rsp_hold_cycles = 300;
      send_random_matrix(24, 1'b1);
      send_random_matrix(8, 1'b1);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall,
                                    input logic [NUM_COLS_W-1:0] cols);
      int start;
      int unsigned len;
      write_num_cols(cols);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      start = requests_sent;
      while (requests_sent - start < 50) begin
         if ($urandom_range(99) < 8) len = $urandom_range(20, 40);
         else len = $urandom_range(1, 10);
         send_random_matrix(len, $urandom_range(99) >= 20);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_column_range();
      test_midload_reconfig();
      test_store_overflow();
      test_receiver_holdoff();
      test_random_phase(0, 0, 5'd16);
      test_random_phase(67, 0, 5'd1);
      test_random_phase(0, 67, 5'd31);
      test_random_phase(29, 29, 5'($urandom_range(2, 15)));
      wait_drained();
      $display("run covered %0d requests in %0d matrices, %0d transposed terms checked",
               requests_sent, matrices_sent, terms_checked);
      $display("num_cols 0 through 31, empty and overfull matrices, long receiver hold-off");
      if (fail_count == 0 && expected_terms.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
